[src/sdf_pkg.sv]
// Package for the serial command deframer.
// Holds the frame byte codes, the queue beat type and the shared sizes.
// No dependencies.
`default_nettype none

package sdf_pkg;

  localparam logic [7:0] START_BYTE   = 8'h01;
  localparam logic [7:0] END_BYTE     = 8'h04;
  localparam logic [8:0] HEADER_BYTES = 9'd3;

  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_BITS    = 3;
  localparam int unsigned OUT_BITS    = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic STATUS_GOOD    = 1'b0;
  localparam logic STATUS_BAD_END = 1'b1;

  typedef enum logic [1:0] {
    BEAT_LEN,
    BEAT_CMD,
    BEAT_DATA,
    BEAT_END
  } beat_kind_e;

  typedef struct packed {
    beat_kind_e          kind;
    logic                keep;
    logic [IDX_BITS-1:0] idx;
    logic [7:0]          data;
  } beat_t;

endpackage

`default_nettype wire

[src/sdf_if.sv]
// Stream interfaces of the serial command deframer: received bytes in,
// decoded frames out. Depends on sdf_pkg.
`default_nettype none

interface sdf_rx_if import sdf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdf_frame_if import sdf_pkg::*;;
  logic                valid;
  logic                ready;
  logic                frame_status;
  logic [7:0]          command_code;
  logic [7:0]          payload_length;
  logic [OUT_BITS-1:0] payload_bytes;
  logic                truncated;

  modport source (output valid, output frame_status, output command_code,
                  output payload_length, output payload_bytes, output truncated,
                  input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input payload_length, input payload_bytes, input truncated,
                  output ready);
endinterface

`default_nettype wire

[src/serial_command_deframer_top.sv]
// Top level of the serial command deframer.
// Depends on sdf_pkg, sdf_if, sdf_front, sdf_queue and sdf_back.
`default_nettype none

// Accepts one received byte per cycle and finds frames of the form start
// byte 0x01, length, command, payload, end byte 0x04; bytes outside a frame
// are ignored. Each frame gives one beat on frame_o with the command, the
// length as received, up to PAYLOAD_BYTES stored payload bytes (byte 0 in
// bits 7:0, the rest zero), a truncated flag when the length exceeds the
// buffer, and frame_status 1 when the closing byte is not 0x04. Each byte
// is classified from the front position counter and pushed into a
// two-entry queue; the back end applies the queued beats and holds each
// finished frame in an output register. While a finished frame waits on
// frame_o, the queue keeps taking bytes; rx_i stalls only once it is full.
module serial_command_deframer_top import sdf_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sdf_rx_if.sink      rx_i,
  sdf_frame_if.source frame_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  beat_t push_beat, pop_beat;

  sdf_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk_i,
    .rst_ni,
    .rx_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_beat_o  (push_beat)
  );

  sdf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_beat_i  (push_beat),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_beat_o   (pop_beat)
  );

  sdf_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_beat_i  (pop_beat),
    .frame_o
  );

endmodule

`default_nettype wire

[src/sdf_front.sv]
// Front end of the deframer: tracks the byte position and classifies each
// received byte into a queue beat. Depends on sdf_pkg and sdf_if.
`default_nettype none

module sdf_front import sdf_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdf_rx_if.sink     rx_i,
  output logic       push_valid_o,
  input  wire logic  push_ready_i,
  output beat_t      push_beat_o
);

  logic [8:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [8:0] end_pos;
  logic [8:0] data_idx;
  logic       accept;

  assign rx_i.ready = push_ready_i;
  assign accept     = rx_i.valid && push_ready_i;
  assign end_pos    = {1'b0, len_q} + HEADER_BYTES;
  assign data_idx   = pos_q - HEADER_BYTES;

  always_comb begin
    pos_d             = pos_q;
    len_d             = len_q;
    push_valid_o      = 1'b0;
    push_beat_o.kind  = BEAT_END;
    push_beat_o.keep  = 1'b0;
    push_beat_o.idx   = data_idx[IDX_BITS-1:0];
    push_beat_o.data  = rx_i.rx_byte;
    if (pos_q == 9'd0) begin
      if (accept && rx_i.rx_byte == START_BYTE) begin
        pos_d = 9'd1;
      end
    end else if (pos_q == 9'd1) begin
      push_valid_o     = rx_i.valid;
      push_beat_o.kind = BEAT_LEN;
      if (accept) begin
        len_d = rx_i.rx_byte;
        pos_d = 9'd2;
      end
    end else if (pos_q == 9'd2) begin
      push_valid_o     = rx_i.valid;
      push_beat_o.kind = BEAT_CMD;
      if (accept) begin
        pos_d = 9'd3;
      end
    end else if (pos_q < end_pos) begin
      push_valid_o     = rx_i.valid;
      push_beat_o.kind = BEAT_DATA;
      push_beat_o.keep = data_idx < 9'(PAYLOAD_BYTES);
      if (accept) begin
        pos_d = pos_q + 9'd1;
      end
    end else begin
      push_valid_o     = rx_i.valid;
      push_beat_o.kind = BEAT_END;
      if (accept) begin
        pos_d = 9'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 9'd0;
      len_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

[src/sdf_queue.sv]
// Two-entry beat queue between the deframer front and back ends.
// Depends on sdf_pkg.
`default_nettype none

module sdf_queue import sdf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire beat_t push_beat_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output beat_t      pop_beat_o
);

  localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);

  beat_t              slot_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = count_q != (PtrBits+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_beat_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

`default_nettype wire

[src/sdf_back.sv]
// Back end of the deframer: applies queued beats to the frame registers
// and payload buffer, and holds the finished frame in an output register.
// Depends on sdf_pkg and sdf_if.
`default_nettype none

module sdf_back import sdf_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire beat_t pop_beat_i,
  sdf_frame_if.source frame_o
);

  localparam int unsigned IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [7:0]          store_q [PAYLOAD_BYTES];
  logic [7:0]          len_q, cmd_q;
  logic [OUT_BITS-1:0] packed_bytes;
  logic                out_valid_q;
  logic                out_status_q, out_trunc_q;
  logic [7:0]          out_cmd_q, out_len_q;
  logic [OUT_BITS-1:0] out_bytes_q;
  logic                pop, slot_free;

  assign slot_free   = !out_valid_q || frame_o.ready;
  assign pop_ready_o = (pop_beat_i.kind != BEAT_END) || slot_free;
  assign pop         = pop_valid_i && pop_ready_o;

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_pack
    if (k < PAYLOAD_BYTES) begin : g_live
      assign packed_bytes[8*k +: 8] = (8'(k) < len_q) ? store_q[k] : 8'd0;
    end else begin : g_zero
      assign packed_bytes[8*k +: 8] = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 8'd0;
      cmd_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        unique case (pop_beat_i.kind)
          BEAT_LEN:  len_q <= pop_beat_i.data;
          BEAT_CMD:  cmd_q <= pop_beat_i.data;
          BEAT_DATA: ;
          BEAT_END:  out_valid_q <= 1'b1;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && pop_beat_i.kind == BEAT_DATA && pop_beat_i.keep) begin
      store_q[pop_beat_i.idx[IdxW-1:0]] <= pop_beat_i.data;
    end
    if (pop && pop_beat_i.kind == BEAT_END) begin
      out_status_q <= (pop_beat_i.data == END_BYTE) ? STATUS_GOOD : STATUS_BAD_END;
      out_cmd_q    <= cmd_q;
      out_len_q    <= len_q;
      out_bytes_q  <= packed_bytes;
      out_trunc_q  <= len_q > 8'(PAYLOAD_BYTES);
    end
  end

  assign frame_o.valid          = out_valid_q;
  assign frame_o.frame_status   = out_status_q;
  assign frame_o.command_code   = out_cmd_q;
  assign frame_o.payload_length = out_len_q;
  assign frame_o.payload_bytes  = out_bytes_q;
  assign frame_o.truncated      = out_trunc_q;

endmodule

`default_nettype wire

[src/sdf_checker.sv]
// Port-level checks for the serial command deframer and their bind
// to serial_command_deframer_top. Depends on sdf_pkg.
`default_nettype none

module sdf_checker import sdf_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                frame_status,
  input wire logic [7:0]          command_code,
  input wire logic [7:0]          payload_length,
  input wire logic [OUT_BITS-1:0] payload_bytes,
  input wire logic                truncated
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("frame beat shown during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled frame beat dropped");

  a_beat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(frame_status) && $stable(command_code)
      && $stable(payload_length) && $stable(payload_bytes) && $stable(truncated))
    else $error("stalled frame beat changed");

  a_trunc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> truncated == (payload_length > 8'(PAYLOAD_BYTES)))
    else $error("truncated flag disagrees with length");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && payload_length < 8'(STORE_DEPTH)
      |-> (payload_bytes >> {payload_length, 3'b000}) == '0)
    else $error("payload bytes past length not zero");

endmodule

bind serial_command_deframer_top sdf_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_sdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (frame_o.valid),
  .out_ready      (frame_o.ready),
  .frame_status   (frame_o.frame_status),
  .command_code   (frame_o.command_code),
  .payload_length (frame_o.payload_length),
  .payload_bytes  (frame_o.payload_bytes),
  .truncated      (frame_o.truncated)
);

`default_nettype wire
